// ----- src/plt_pkg.sv -----
// Package for the positional list table: field widths, the operation codes
// and the default record capacity.
// No dependencies; positional_list_table imports it.
package plt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CNT_W   = 7;

  localparam int unsigned REC_W = CODE_W + PRICE_W;

  // Input payload: index, entry_code, entry_price, padded to whole bytes.
  localparam int unsigned IN_RAW_W   = IDX_W + CODE_W + PRICE_W;
  localparam int unsigned IN_TDATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W = MODE_W;

  // Output payload: out_code, out_price, position, count, padded to bytes.
  localparam int unsigned OUT_RAW_W   = CODE_W + PRICE_W + POS_W + CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 1;

  typedef enum logic [MODE_W-1:0] {
    M_INSERT_AT   = 3'd0,
    M_APPEND      = 3'd1,
    M_REMOVE_AT   = 3'd2,
    M_REMOVE_LAST = 3'd3,
    M_REMOVE_CODE = 3'd4,
    M_FIND_CODE   = 3'd5,
    M_READ_AT     = 3'd6,
    M_CLEAR       = 3'd7
  } mode_e;

endpackage

// ----- src/plt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used by the positional list table for its record store.
module plt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/positional_list_table.sv -----
// Top level of the positional list table: control sequencer, count register
// and result register around one record RAM. Depends on plt_pkg and plt_ram.
//
// The block keeps an ordered list of up to CAPACITY records, each a
// code and a price word, in one RAM with a registered read.
// One word on the slave stream carries one operation: tuser selects it
// (insert at index, append, remove at index, remove last, remove by code,
// find by code, read at index, clear) and tdata carries index, code, price.
// Every accepted word gives exactly one result word on the master stream:
// tuser holds the ok flag, tdata the record, its position and the count.
// The block works on one word at a time; s_axis_tready is high only while
// the sequencer is idle. Clear and failed index checks go straight to the
// result; append writes the new record, read at index and remove last read
// one record. Insert moves each record behind the position up by one
// through the single RAM port pair, one record per cycle, then writes the
// new one; remove at index moves the records behind it down the same way.
// Find walks from the front to a hit or the end; remove by code then closes
// the gap behind the hit. The next word is taken the cycle after the result.
// Results wait in an output register; a stalled receiver holds the next
// result in the sequencer, and no new word is taken until it moves on.
// Reset empties the list at once; the record RAM itself is not cleared.
module positional_list_table #(
  parameter int unsigned CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tuser: mode[2:0]
  input  logic [plt_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  // tdata: index[6:0], entry_code[38:7], entry_price[70:39], zero padding
  input  logic [plt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tuser: ok[0]
  output logic [plt_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  // tdata: out_code[31:0], out_price[63:32], position[69:64],
  //        count[76:70], zero padding
  output logic [plt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);

  import plt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Wide enough to hold the count, any address and any index unchanged.
  localparam int unsigned WW = CW + IDX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DOWN = 6'b000100,
    S_UP   = 6'b001000,
    S_WNEW = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  mode_e                op_q, op_d;
  logic [CODE_W-1:0]    code_q, code_d;
  logic [PRICE_W-1:0]   price_q, price_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [AW-1:0]        raddr_q, raddr_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        paddr_q, paddr_d;

  logic                 res_ok_q, res_ok_d;
  logic [CODE_W-1:0]    res_code_q, res_code_d;
  logic [PRICE_W-1:0]   res_price_q, res_price_d;
  logic [AW-1:0]        res_pos_q, res_pos_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_ok_q, out_ok_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [REC_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [REC_W-1:0]     mem_rdata;
  logic [CODE_W-1:0]    rd_code;
  logic [PRICE_W-1:0]   rd_price;

  logic [IDX_W-1:0]     in_idx;
  logic [CODE_W-1:0]    in_code;
  logic [PRICE_W-1:0]   in_price;
  logic [WW-1:0]        idx_wide;
  logic [WW-1:0]        cnt_wide;
  logic [WW-1:0]        pos_wide;
  logic                 list_full;
  logic                 list_empty;
  logic                 idx_in_list;
  logic [AW-1:0]        idx_addr;
  logic [AW-1:0]        ins_pos;
  logic                 hit;

  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_code  = s_axis_tdata[IDX_W +: CODE_W];
  assign in_price = s_axis_tdata[IDX_W+CODE_W +: PRICE_W];

  assign rd_code  = mem_rdata[CODE_W-1:0];
  assign rd_price = mem_rdata[CODE_W +: PRICE_W];

  assign idx_wide    = WW'(in_idx);
  assign cnt_wide    = WW'(cnt_q);
  assign pos_wide    = WW'(res_pos_q);
  assign list_full   = (cnt_q == CW'(CAPACITY));
  assign list_empty  = (cnt_q == '0);
  assign idx_in_list = (idx_wide < cnt_wide);
  assign idx_addr    = AW'(in_idx);
  // Inserting past the end lands right behind the last record.
  assign ins_pos     = idx_in_list ? idx_addr : AW'(cnt_q);
  assign hit         = pend_q && (rd_code == code_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = out_data_q;

  plt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    code_d      = code_q;
    price_d     = price_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    raddr_d     = raddr_q;
    pend_d      = pend_q;
    paddr_d     = paddr_q;
    res_ok_d    = res_ok_q;
    res_code_d  = res_code_q;
    res_price_d = res_price_q;
    res_pos_d   = res_pos_q;
    out_ok_d    = out_ok_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;

    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = {price_q, code_q};
    mem_re    = 1'b0;
    mem_raddr = raddr_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d        = mode_e'(s_axis_tuser[MODE_W-1:0]);
          code_d      = in_code;
          price_d     = in_price;
          pend_d      = 1'b0;
          res_ok_d    = 1'b0;
          res_code_d  = '0;
          res_price_d = '0;
          res_pos_d   = '0;
          // Failing cases go straight to the result with the zeroed record.
          state_d     = S_DONE;
          case (mode_e'(s_axis_tuser[MODE_W-1:0]))
            M_INSERT_AT: begin
              if (!list_full && !(list_empty && in_idx != '0)) begin
                pos_d   = ins_pos;
                rem_d   = cnt_q - CW'(ins_pos);
                raddr_d = AW'(cnt_q - CW'(1));
                state_d = S_DOWN;
              end
            end
            M_APPEND: begin
              if (!list_full) begin
                pos_d   = AW'(cnt_q);
                rem_d   = '0;
                state_d = S_DOWN;
              end
            end
            M_REMOVE_AT: begin
              if (idx_in_list) begin
                pos_d   = idx_addr;
                raddr_d = idx_addr;
                rem_d   = cnt_q - CW'(idx_addr);
                state_d = S_UP;
              end
            end
            M_REMOVE_LAST: begin
              if (!list_empty) begin
                pos_d   = AW'(cnt_q - CW'(1));
                raddr_d = AW'(cnt_q - CW'(1));
                rem_d   = CW'(1);
                state_d = S_UP;
              end
            end
            M_REMOVE_CODE, M_FIND_CODE: begin
              raddr_d = '0;
              rem_d   = cnt_q;
              state_d = S_SCAN;
            end
            M_READ_AT: begin
              if (idx_in_list) begin
                pos_d   = idx_addr;
                raddr_d = idx_addr;
                rem_d   = CW'(1);
                state_d = S_UP;
              end
            end
            M_CLEAR: begin
              cnt_d    = '0;
              res_ok_d = 1'b1;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          pos_d  = paddr_q;
          pend_d = 1'b0;
          if (op_q == M_FIND_CODE) begin
            res_ok_d    = 1'b1;
            res_code_d  = rd_code;
            res_price_d = rd_price;
            res_pos_d   = paddr_q;
            state_d     = S_DONE;
          end else begin
            // Remove the matching record with the ordinary close-up pass.
            raddr_d = paddr_q;
            rem_d   = cnt_q - CW'(paddr_q);
            state_d = S_UP;
          end
        end else if (rem_q != '0) begin
          mem_re  = 1'b1;
          raddr_d = raddr_q + AW'(1);
          rem_d   = rem_q - CW'(1);
          pend_d  = 1'b1;
          paddr_d = raddr_q;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_DONE;
          end
        end
      end

      S_DOWN: begin
        // Open a gap: each record read in the previous cycle moves up by one.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (rem_q != '0) begin
          mem_re  = 1'b1;
          raddr_d = raddr_q - AW'(1);
          rem_d   = rem_q - CW'(1);
          pend_d  = 1'b1;
          paddr_d = raddr_q;
        end else begin
          pend_d  = 1'b0;
          state_d = S_WNEW;
        end
      end

      S_WNEW: begin
        mem_we      = 1'b1;
        cnt_d       = cnt_q + CW'(1);
        res_ok_d    = 1'b1;
        res_code_d  = code_q;
        res_price_d = price_q;
        res_pos_d   = pos_q;
        state_d     = S_DONE;
      end

      S_UP: begin
        // The first record read is the result; the ones behind it move
        // down by one to close the gap.
        if (pend_q) begin
          if (paddr_q == pos_q) begin
            res_code_d  = rd_code;
            res_price_d = rd_price;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = paddr_q - AW'(1);
            mem_wdata = mem_rdata;
          end
        end
        if (rem_q != '0) begin
          mem_re  = 1'b1;
          raddr_d = raddr_q + AW'(1);
          rem_d   = rem_q - CW'(1);
          pend_d  = 1'b1;
          paddr_d = raddr_q;
        end else begin
          pend_d    = 1'b0;
          res_ok_d  = 1'b1;
          res_pos_d = pos_q;
          if (op_q != M_READ_AT) begin
            cnt_d = cnt_q - CW'(1);
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_data_d  = OUT_TDATA_W'({cnt_wide[CNT_W-1:0], pos_wide[POS_W-1:0],
                                      res_price_q, res_code_q});
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    code_q      <= code_d;
    price_q     <= price_d;
    pos_q       <= pos_d;
    rem_q       <= rem_d;
    raddr_q     <= raddr_d;
    paddr_q     <= paddr_d;
    res_ok_q    <= res_ok_d;
    res_code_q  <= res_code_d;
    res_price_q <= res_price_d;
    res_pos_q   <= res_pos_d;
    out_ok_q    <= out_ok_d;
    out_data_q  <= out_data_d;
  end

endmodule
